[rtl/swc_pkg.sv]
// Shared types and constants for the sliding-window covariance estimator.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package swc_pkg;

  localparam int COORD_W   = 24;  // signed Q12.12 coordinate
  localparam int VALUE_W   = 48;  // signed result value
  localparam int COUNT_W   = 11;  // point count and window registers
  localparam int DIMREG_W  = 4;
  localparam int FLOOR_W   = 24;
  localparam int SUM_W     = 58;  // exact running sums
  localparam int MEAN_W    = 25;  // rounded mean, signed
  localparam int PROD_W    = 2 * COORD_W;
  localparam int CPROD_W   = 2 * MEAN_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int ROW_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FILL       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_FLOOR = 2'd3;

  localparam logic               KIND_MEAN = 1'b0;
  localparam logic               KIND_COV  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_COPY,
    ST_ACC_RD,
    ST_ACC_MUL,
    ST_ACC_WR,
    ST_EM_RD,
    ST_EM_LOAD,
    ST_DIV,
    ST_EM_MUL,
    ST_EM_FIN
  } state_t;

endpackage
`default_nettype wire

[rtl/swc_ifs.sv]
// Valid/ready channel interfaces for coordinate items and result items.
// Depends on swc_pkg for field widths.
`default_nettype none
interface swc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [swc_pkg::COORD_W-1:0]  coordinate;
  logic                                point_end;
  modport source (output valid, output coordinate, output point_end, input ready);
  modport sink   (input valid, input coordinate, input point_end, output ready);
endinterface

interface swc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                entry_kind;
  logic [swc_pkg::ROW_W-1:0]           row;
  logic [swc_pkg::ROW_W-1:0]           col;
  logic signed [swc_pkg::VALUE_W-1:0]  value;
  logic [swc_pkg::COUNT_W-1:0]         window_count;
  logic                                window_ready;
  logic                                last;
  modport source (output valid, output entry_kind, output row, output col, output value,
                  output window_count, output window_ready, output last, input ready);
  modport sink   (input valid, input entry_kind, input row, input col, input value,
                  input window_count, input window_ready, input last, output ready);
endinterface
`default_nettype wire

[rtl/sliding_window_covariance.sv]
// Sliding-window mean and covariance estimator. Depends on swc_pkg and swc_ifs.
// A coordinate item without the point-end mark is stored in a pending register. A point-end item
// starts a sequencer around one shared multiplier, one add/subtract for the running
// sums and a restoring divider. A check state first compares the count with the
// window length: while the window is full, the oldest point is read from the ring
// store and subtracted from the sums term by term, and the check repeats. Then the
// new point is copied into the ring store and added to the sums. Each mean result
// and then each covariance result comes from the bit-serial divider, which divides
// its sum by the window count; means of unused coordinates are skipped. Input ready
// is low from the point-end item until the last result is loaded, including any
// wait on the result side. Results are offered through an output register.
`default_nettype none
module sliding_window_covariance #(
  parameter int WINDOW_DEPTH = 1024,
  parameter int MAX_DIMS     = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [swc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [swc_pkg::CFG_DATA_W-1:0]    cfg_data,
  swc_in_if.sink                                 point_in,
  swc_out_if.source                              result_out
);

  localparam int NTERMS = MAX_DIMS + MAX_DIMS * (MAX_DIMS + 1) / 2;
  localparam int HW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int IW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DIM_W  = $clog2(MAX_DIMS + 1);
  localparam int TW     = $clog2(NTERMS);
  localparam int SDEPTH = WINDOW_DEPTH * MAX_DIMS;
  localparam int SA_W   = $clog2(SDEPTH);
  localparam int SW     = swc_pkg::SUM_W;
  localparam logic signed [SW+1:0] SAT_HI = 60'sh7FFF_FFFF_FFFF;
  localparam logic signed [SW+1:0] SAT_LO = -60'sh8000_0000_0000;

  swc_pkg::state_t state, state_next;

  logic [swc_pkg::COUNT_W-1:0]  wl, mf;
  logic [swc_pkg::DIMREG_W-1:0] dimr;
  logic [swc_pkg::FLOOR_W-1:0]  vf;

  logic signed [swc_pkg::COORD_W-1:0] pending [MAX_DIMS];
  logic [DIM_W-1:0]             cidx;
  logic [HW-1:0]                head, slot;
  logic [swc_pkg::COUNT_W-1:0]  count;
  logic                         acc_add;
  logic [TW-1:0]                t;
  logic [IW-1:0]                r, c;

  logic signed [swc_pkg::COORD_W-1:0] store [SDEPTH];
  logic signed [swc_pkg::COORD_W-1:0] qa, qb;
  logic signed [SW-1:0]         sums [NTERMS];
  logic [NTERMS-1:0]            sums_v;
  logic signed [SW-1:0]         sd_raw;
  logic                         sdv;
  logic signed [swc_pkg::MEAN_W-1:0] means [MAX_DIMS];
  logic signed [swc_pkg::MEAN_W-1:0] ma, mb;

  logic signed [swc_pkg::PROD_W-1:0]  prodacc;
  logic signed [swc_pkg::CPROD_W-1:0] cprod;
  logic [SW-1:0]                dq;
  logic [swc_pkg::COUNT_W-1:0]  rem;
  logic [5:0]                   dcnt;
  logic                         neg;

  // combinational helpers
  logic [swc_pkg::COUNT_W-1:0]  len_eff;
  logic [DIM_W-1:0]             dims_eff;
  logic                         in_acc, is_mean, skip_means, fin_load, is_last;
  logic [TW-1:0]                t_adv;
  logic [IW-1:0]                r_adv, c_adv;
  logic [SA_W-1:0]              addr_a, addr_b, addr_w;
  logic signed [SW-1:0]         sd, term;
  logic [31:0]                  tail32, head_inc32;
  logic [swc_pkg::COUNT_W:0]    rem_sh;
  logic                         qbit;
  logic [SW:0]                  qs;
  logic signed [SW+1:0]         diff;
  logic signed [swc_pkg::VALUE_W-1:0] cov_v, res_v;
  logic [SW-1:0]                mag;
  logic signed [swc_pkg::MEAN_W-1:0]  mul_a, mul_b;
  logic signed [swc_pkg::CPROD_W-1:0] mul_p;

  always_comb begin
    if (wl == '0) len_eff = swc_pkg::COUNT_W'(1);
    else if (32'(wl) > WINDOW_DEPTH) len_eff = swc_pkg::COUNT_W'(WINDOW_DEPTH);
    else len_eff = wl;
    if (dimr == '0) dims_eff = DIM_W'(1);
    else if (32'(dimr) > MAX_DIMS) dims_eff = DIM_W'(MAX_DIMS);
    else dims_eff = DIM_W'(dimr);
  end

  assign in_acc     = point_in.valid && point_in.ready;
  assign is_mean    = 32'(t) < MAX_DIMS;
  assign skip_means = is_mean && (32'(r) >= 32'(dims_eff));
  assign fin_load   = !result_out.valid || result_out.ready;
  assign is_last    = !is_mean && (32'(r) == 32'(dims_eff) - 1) && (c == r);
  assign sd         = sdv ? sd_raw : '0;

  // walk the means, then the lower triangle row by row
  always_comb begin
    t_adv = t + TW'(1);
    r_adv = r;
    c_adv = c;
    if (32'(t) == MAX_DIMS - 1) begin
      r_adv = '0;
      c_adv = '0;
    end else if (is_mean) begin
      r_adv = r + IW'(1);
    end else if (c == r) begin
      r_adv = r + IW'(1);
      c_adv = '0;
    end else begin
      c_adv = c + IW'(1);
    end
  end

  assign addr_a     = SA_W'(32'(slot) * MAX_DIMS + 32'(r));
  assign addr_b     = SA_W'(32'(slot) * MAX_DIMS + 32'(c));
  assign addr_w     = addr_a;
  assign tail32     = (32'(head) + 32'(count) >= WINDOW_DEPTH)
                      ? 32'(head) + 32'(count) - WINDOW_DEPTH : 32'(head) + 32'(count);
  assign head_inc32 = (32'(head) + 1 >= WINDOW_DEPTH) ? 32'd0 : 32'(head) + 1;
  assign term       = is_mean ? SW'(qa) : SW'(prodacc);
  assign mag        = sd[SW-1] ? SW'(-sd) : sd;

  // one multiplier serves the sum update and the product of means
  assign mul_a      = (state == swc_pkg::ST_EM_MUL) ? ma : swc_pkg::MEAN_W'(qa);
  assign mul_b      = (state == swc_pkg::ST_EM_MUL) ? mb : swc_pkg::MEAN_W'(qb);
  assign mul_p      = mul_a * mul_b;

  always_comb begin
    rem_sh = {rem, dq[SW-1]};
    qbit   = rem_sh >= {1'b0, count};
  end

  always_comb begin
    qs    = neg ? (SW+1)'(-$signed({1'b0, dq})) : {1'b0, dq};
    diff  = (SW+2)'($signed(qs)) - (SW+2)'(cprod);
    if (diff > SAT_HI) cov_v = SAT_HI[swc_pkg::VALUE_W-1:0];
    else if (diff < SAT_LO) cov_v = SAT_LO[swc_pkg::VALUE_W-1:0];
    else cov_v = diff[swc_pkg::VALUE_W-1:0];
    if (r == c && cov_v <= 0)
      cov_v = (vf == '0) ? swc_pkg::VALUE_W'(1) : swc_pkg::VALUE_W'(vf);
    res_v = is_mean ? qs[swc_pkg::VALUE_W-1:0] : cov_v;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      swc_pkg::ST_IDLE:    if (in_acc && point_in.point_end) state_next = swc_pkg::ST_CHECK;
      swc_pkg::ST_CHECK:   state_next = (count >= len_eff) ? swc_pkg::ST_ACC_RD
                                                           : swc_pkg::ST_COPY;
      swc_pkg::ST_COPY:    if (32'(r) == MAX_DIMS - 1) state_next = swc_pkg::ST_ACC_RD;
      swc_pkg::ST_ACC_RD:  state_next = swc_pkg::ST_ACC_MUL;
      swc_pkg::ST_ACC_MUL: state_next = swc_pkg::ST_ACC_WR;
      swc_pkg::ST_ACC_WR: begin
        if (32'(t) != NTERMS - 1) state_next = swc_pkg::ST_ACC_RD;
        else state_next = acc_add ? swc_pkg::ST_EM_RD : swc_pkg::ST_CHECK;
      end
      swc_pkg::ST_EM_RD:   if (!skip_means) state_next = swc_pkg::ST_EM_LOAD;
      swc_pkg::ST_EM_LOAD: state_next = swc_pkg::ST_DIV;
      swc_pkg::ST_DIV: begin
        if (32'(dcnt) == SW - 1)
          state_next = is_mean ? swc_pkg::ST_EM_FIN : swc_pkg::ST_EM_MUL;
      end
      swc_pkg::ST_EM_MUL:  state_next = swc_pkg::ST_EM_FIN;
      swc_pkg::ST_EM_FIN: begin
        if (fin_load) state_next = is_last ? swc_pkg::ST_IDLE : swc_pkg::ST_EM_RD;
      end
      default:             state_next = swc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    point_in.ready = (state == swc_pkg::ST_IDLE);
  end

  // ring store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (state == swc_pkg::ST_COPY) store[addr_w] <= pending[r];
    qa <= store[addr_a];
    qb <= store[addr_b];
  end

  // running sums
  always_ff @(posedge clk) begin
    if (state == swc_pkg::ST_ACC_WR) sums[t] <= acc_add ? sd + term : sd - term;
    sd_raw <= sums[t];
  end

  // means of the current run
  always_ff @(posedge clk) begin
    if (state == swc_pkg::ST_EM_FIN && fin_load && is_mean)
      means[r] <= qs[swc_pkg::MEAN_W-1:0];
    ma <= means[r];
    mb <= means[c];
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    unique case (state)
      swc_pkg::ST_ACC_MUL: prodacc <= mul_p[swc_pkg::PROD_W-1:0];
      swc_pkg::ST_EM_LOAD: begin
        neg  <= sd[SW-1];
        dq   <= mag + SW'(count >> 1);
        rem  <= '0;
        dcnt <= '0;
      end
      swc_pkg::ST_DIV: begin
        rem  <= qbit ? swc_pkg::COUNT_W'(rem_sh - {1'b0, count})
                     : rem_sh[swc_pkg::COUNT_W-1:0];
        dq   <= {dq[SW-2:0], qbit};
        dcnt <= dcnt + 6'd1;
      end
      swc_pkg::ST_EM_MUL:  cprod <= mul_p;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= swc_pkg::ST_IDLE;
      wl     <= swc_pkg::COUNT_W'(1024);
      mf     <= swc_pkg::COUNT_W'(1024);
      dimr   <= swc_pkg::DIMREG_W'(8);
      vf     <= swc_pkg::FLOOR_W'(1);
      for (int i = 0; i < MAX_DIMS; i++) pending[i] <= '0;
      cidx   <= '0;
      head   <= '0;
      slot   <= '0;
      count  <= '0;
      acc_add <= 1'b0;
      t      <= '0;
      r      <= '0;
      c      <= '0;
      sums_v <= '0;
      sdv    <= 1'b0;
      result_out.valid <= 1'b0;
    end else begin
      state <= state_next;
      sdv   <= sums_v[t];
      if (cfg_we) begin
        unique case (cfg_index)
          swc_pkg::REG_WINDOW_LENGTH:  wl   <= cfg_data[swc_pkg::COUNT_W-1:0];
          swc_pkg::REG_MIN_FILL:       mf   <= cfg_data[swc_pkg::COUNT_W-1:0];
          swc_pkg::REG_DIMENSIONS:     dimr <= cfg_data[swc_pkg::DIMREG_W-1:0];
          swc_pkg::REG_VARIANCE_FLOOR: vf   <= cfg_data[swc_pkg::FLOOR_W-1:0];
          default: ;
        endcase
      end
      // drop valid once taken, unless a new item is loaded in the same cycle
      if (result_out.valid && result_out.ready
          && !(state == swc_pkg::ST_EM_FIN && fin_load)) result_out.valid <= 1'b0;
      unique case (state)
        swc_pkg::ST_IDLE: begin
          if (in_acc) begin
            // ignore coordinates beyond the dimensions in use
            if (32'(cidx) < 32'(dims_eff)) pending[cidx[IW-1:0]] <= point_in.coordinate;
            if (32'(cidx) < MAX_DIMS) cidx <= cidx + DIM_W'(1);
          end
        end
        swc_pkg::ST_CHECK: begin
          t <= '0;
          r <= '0;
          c <= '0;
          if (count >= len_eff) begin
            slot    <= head;
            acc_add <= 1'b0;
          end else begin
            slot    <= HW'(tail32);
            acc_add <= 1'b1;
          end
        end
        swc_pkg::ST_COPY: begin
          if (32'(r) == MAX_DIMS - 1) begin
            r    <= '0;
            cidx <= '0;
            for (int i = 0; i < MAX_DIMS; i++) pending[i] <= '0;
          end else begin
            r <= r + IW'(1);
          end
        end
        swc_pkg::ST_ACC_WR: begin
          sums_v[t] <= 1'b1;
          if (32'(t) == NTERMS - 1) begin
            t <= '0;
            r <= '0;
            c <= '0;
            if (acc_add) begin
              count <= count + swc_pkg::COUNT_W'(1);
            end else begin
              head  <= HW'(head_inc32);
              count <= count - swc_pkg::COUNT_W'(1);
            end
          end else begin
            t <= t_adv;
            r <= r_adv;
            c <= c_adv;
          end
        end
        swc_pkg::ST_EM_RD: begin
          // skip the means of unused coordinates
          if (skip_means) begin
            t <= TW'(MAX_DIMS);
            r <= '0;
            c <= '0;
          end
        end
        swc_pkg::ST_EM_FIN: begin
          if (fin_load) begin
            result_out.valid        <= 1'b1;
            result_out.entry_kind   <= is_mean ? swc_pkg::KIND_MEAN : swc_pkg::KIND_COV;
            result_out.row          <= swc_pkg::ROW_W'(r);
            result_out.col          <= is_mean ? '0 : swc_pkg::ROW_W'(c);
            result_out.value        <= res_v;
            result_out.window_count <= count;
            result_out.window_ready <= count >= mf;
            result_out.last         <= is_last;
            if (is_last) begin
              t <= '0;
              r <= '0;
              c <= '0;
            end else begin
              t <= t_adv;
              r <= r_adv;
              c <= c_adv;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
